// ===== src/pvrb_pkg.sv =====
// shared types, constants and helper functions of the planar video ram blitter mixer
package pvrb_pkg;

  localparam int VramWords           = 16384;
  localparam int VramAw              = 14;
  localparam int WordW               = 32;
  localparam int GfxHalfBytesDefault = 8192;
  localparam int CfgIdxW             = 3;
  localparam int CfgDataW            = 8;

  // pixel bit patterns of a packed cpu byte
  localparam logic [WordW-1:0] ExpLo = 32'h0000_0055;
  localparam logic [WordW-1:0] ExpHi = 32'h0000_00aa;

  // lane masks selected by the layer mask bits
  localparam logic [WordW-1:0] LaneBit3 = 32'h3030_3030;
  localparam logic [WordW-1:0] LaneBit2 = 32'hc0c0_c0c0;
  localparam logic [WordW-1:0] LaneBit1 = 32'h0303_0303;
  localparam logic [WordW-1:0] LaneBit0 = 32'h0c0c_0c0c;

  typedef enum logic [1:0] {
    ACT_CPU_WRITE   = 2'd0,
    ACT_BLIT_START  = 2'd1,
    ACT_BLIT_DATA   = 2'd2,
    ACT_PIXEL_FETCH = 2'd3
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LAYER_MASK    = 3'd0,
    REG_SCROLL_X      = 3'd1,
    REG_SCROLL_Y      = 3'd2,
    REG_PLANE_CONTROL = 3'd3,
    REG_COLOR_MASKS   = 3'd4
  } reg_index_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MODIFY,
    ST_FETCH_B,
    ST_MIX
  } state_e;

  // controls of the pixel mixer
  typedef struct packed {
    logic       ena;
    logic       enb;
    logic       pra;
    logic       prb;
    logic [3:0] mask_a;
    logic [3:0] mask_b;
  } mix_ctrl_t;

  // spread a DCBADCBA byte over the four pixel lanes
  function automatic logic [WordW-1:0] expand_byte(input logic [7:0] b);
    logic [WordW-1:0] e;
    e = '0;
    for (int i = 0; i < 4; i++) begin
      if (b[i])   e = e | (ExpLo << (8 * i));
      if (b[i+4]) e = e | (ExpHi << (8 * i));
    end
    return e;
  endfunction

  // bit mask of the pixel lanes that a layer mask opens
  function automatic logic [WordW-1:0] lane_mask(input logic [3:0] m);
    logic [WordW-1:0] l;
    l = '0;
    if (m[3]) l = l | LaneBit3;
    if (m[2]) l = l | LaneBit2;
    if (m[1]) l = l | LaneBit1;
    if (m[0]) l = l | LaneBit0;
    return l;
  endfunction

endpackage

// ===== src/pvrb_ram.sv =====
// generic single-port ram with registered read
module pvrb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read first: a write lands in the array, the registered read data holds the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/pvrb_mix.sv =====
// pixel pair mixer: layer enables, priority and second pixel colour masks
module pvrb_mix (
  input  pvrb_pkg::mix_ctrl_t ctrl_i,
  input  logic [3:0]          pa_i,
  input  logic [3:0]          pb_i,
  output logic [2:0]          pen_first_o,
  output logic [2:0]          pen_second_o
);

  import pvrb_pkg::*;

  logic       sel_a;
  logic       sel_b1;
  logic       sel_b2;
  logic [3:0] pa_m;
  logic [3:0] pb_m;
  logic [3:0] pa_2;
  logic [3:0] f1;
  logic [3:0] f2;

  // first pixel at full brightness
  always_comb begin
    sel_a  = ctrl_i.ena && (ctrl_i.pra || (pb_i == 4'd0));
    sel_b1 = ctrl_i.enb && (ctrl_i.prb || (pa_i == 4'd0));
    f1     = (sel_a ? pa_i : 4'd0) | (sel_b1 ? pb_i : 4'd0);
  end

  // second pixel: mask only pixels with bit 3 clear, b test sees masked a
  always_comb begin
    pa_m   = pa_i[3] ? pa_i : (pa_i & ctrl_i.mask_a);
    pb_m   = pb_i[3] ? pb_i : (pb_i & ctrl_i.mask_b);
    pa_2   = sel_a ? pa_m : pa_i;
    sel_b2 = ctrl_i.enb && (ctrl_i.prb || (pa_2 == 4'd0));
    f2     = (sel_a ? pa_m : 4'd0) | (sel_b2 ? pb_m : 4'd0);
  end

  assign pen_first_o  = f1[2:0];
  assign pen_second_o = f2[2:0];

endmodule

// ===== src/planar_video_ram_blitter_mixer.sv =====
// top level: two-layer video ram with cpu writes, blitter and pixel pair mixer
//
// usage:
// - a word is taken at a rising edge with start high and busy low; action_i
//   picks cpu write, blit start, blit data or pixel fetch
// - every word gives exactly one result, shown for one cycle with valid_o
//   high; the receiver cannot hold results off
// - blit start, and blit data with no blit running (blit_error_o set): the
//   result shows in the cycle after the accepting edge, busy stays low
// - cpu write and blit data: read-modify-write of one ram word, read in the
//   idle state and written in the modify state, result in the cycle after the write
// - pixel fetch: two ram reads on the single port, in the idle and fetch_b
//   states, then the mix state, result in the cycle after the mix
// - the single-port video ram sets these steps
// - after reset the ram is cleared one word a cycle, all 16384 words, with busy
//   high; configuration writes are taken at any time (cfg_ready_o is high)
// - configuration must only change while no word is in flight
module planar_video_ram_blitter_mixer #(
  parameter int GFX_HALF_BYTES = pvrb_pkg::GfxHalfBytesDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   action_i,
  input  logic [13:0]                  write_address_i,
  input  logic [7:0]                   write_byte_i,
  input  logic [15:0]                  blit_source_start_i,
  input  logic [15:0]                  blit_dest_start_i,
  input  logic [7:0]                   blit_width_i,
  input  logic [7:0]                   blit_height_i,
  input  logic [7:0]                   plane_a_byte_i,
  input  logic [7:0]                   plane_b_byte_i,
  input  logic [7:0]                   pixel_col_i,
  input  logic [7:0]                   pixel_row_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pvrb_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [pvrb_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                         valid_o,
  output logic [2:0]                   pen_first_o,
  output logic [2:0]                   pen_second_o,
  output logic [12:0]                  blit_source_o,
  output logic                         blit_done_o,
  output logic                         blit_error_o
);

  import pvrb_pkg::*;

  localparam logic [15:0] SrcMask = 16'(GFX_HALF_BYTES - 1);

  state_e state_q, state_d;
  logic [VramAw-1:0] clr_q;

  // configuration registers
  logic [3:0] layer_mask_q;
  logic [7:0] scroll_x_q;
  logic [7:0] scroll_y_q;
  logic [5:0] plane_control_q;
  logic [5:0] color_masks_q;

  // blitter state
  logic [15:0] source_counter_q;
  logic [15:0] row_dest_base_q;
  logic [7:0]  column_count_q;
  logic [7:0]  row_count_q;
  logic [7:0]  width_latch_q;
  logic [7:0]  height_latch_q;
  logic        blit_active_q;

  // word in flight
  action_e           act_q;
  logic [VramAw-1:0] addr_q;
  logic [7:0]        byte_a_q;
  logic [7:0]        byte_b_q;
  logic [1:0]        xa_lo_q;
  logic [1:0]        xb_lo_q;
  logic [3:0]        pa_q;

  // result registers
  logic        valid_q;
  logic [2:0]  pen1_q;
  logic [2:0]  pen2_q;
  logic [12:0] src_q;
  logic        done_q;
  logic        err_q;

  action_e     act_in;
  logic        accept;
  logic        valid_d;
  logic [7:0]  xa, ya, xb, yb;
  logic [VramAw-1:0] pix_addr_a;
  logic [VramAw-1:0] pix_addr_b;
  logic [15:0] dst_sum;
  logic [VramAw-1:0] blit_dst;
  logic [15:0] src_sel;
  logic        last_col;
  logic        last_step;

  logic              ram_we;
  logic [VramAw-1:0] ram_addr;
  logic [WordW-1:0]  ram_wdata;
  logic [WordW-1:0]  ram_rdata;

  logic [3:0]       m_or;
  logic [WordW-1:0] lanes_a;
  logic [WordW-1:0] lanes_b;
  logic [WordW-1:0] step_word;
  logic [WordW-1:0] merged;

  mix_ctrl_t  mix_ctrl;
  logic [3:0] pb_nib;
  logic [2:0] mix_pen1;
  logic [2:0] mix_pen2;

  assign act_in      = action_e'(action_i);
  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  // pixel addresses of both layers: layer a flipped and scrolled, layer b flipped
  always_comb begin
    xa         = scroll_x_q + (pixel_col_i ^ {8{plane_control_q[5]}});
    ya         = scroll_y_q + (pixel_row_i ^ {8{plane_control_q[5]}});
    xb         = pixel_col_i ^ {8{plane_control_q[4]}};
    yb         = pixel_row_i ^ {8{plane_control_q[4]}};
    pix_addr_a = {xa[7:2], ya};
    pix_addr_b = {xb[7:2], yb};
  end

  // blit step address, source and end tests
  always_comb begin
    dst_sum   = row_dest_base_q + {8'd0, column_count_q};
    blit_dst  = dst_sum[VramAw-1:0];
    src_sel   = source_counter_q & SrcMask;
    last_col  = (column_count_q == width_latch_q);
    last_step = last_col && (row_count_q == height_latch_q);
  end

  // merge of the read word with up to two expanded bytes
  always_comb begin
    m_or = {{2{|layer_mask_q[3:2]}}, {2{|layer_mask_q[1:0]}}};
    if (act_q == ACT_BLIT_DATA) begin
      lanes_a = lane_mask(m_or & 4'b0101);
      lanes_b = lane_mask(m_or & 4'b1010);
    end else begin
      lanes_a = lane_mask(layer_mask_q);
      lanes_b = '0;
    end
    step_word = (ram_rdata & ~lanes_a) | (expand_byte(byte_a_q) & lanes_a);
    merged    = (step_word & ~lanes_b) | (expand_byte(byte_b_q) & lanes_b);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (&clr_q) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (act_in)
            ACT_CPU_WRITE:   state_d = ST_MODIFY;
            ACT_BLIT_START:  state_d = ST_IDLE;
            ACT_BLIT_DATA:   state_d = blit_active_q ? ST_MODIFY : ST_IDLE;
            ACT_PIXEL_FETCH: state_d = ST_FETCH_B;
            default:         state_d = ST_IDLE;
          endcase
        end
      end
      ST_MODIFY:  state_d = ST_IDLE;
      ST_FETCH_B: state_d = ST_MIX;
      ST_MIX:     state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // ram port control
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = addr_q;
    ram_wdata = merged;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        unique case (act_in)
          ACT_CPU_WRITE:   ram_addr = write_address_i;
          ACT_PIXEL_FETCH: ram_addr = pix_addr_a;
          default:         ram_addr = blit_dst;
        endcase
      end
      ST_MODIFY: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // result strobe
  always_comb begin
    valid_d = (state_q == ST_MODIFY) || (state_q == ST_MIX);
    if (accept && ((act_in == ACT_BLIT_START) ||
                   ((act_in == ACT_BLIT_DATA) && !blit_active_q))) begin
      valid_d = 1'b1;
    end
  end

  // control, configuration and blitter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_CLEAR;
      clr_q            <= '0;
      layer_mask_q     <= '0;
      scroll_x_q       <= '0;
      scroll_y_q       <= '0;
      plane_control_q  <= '0;
      color_masks_q    <= '0;
      source_counter_q <= '0;
      row_dest_base_q  <= '0;
      column_count_q   <= '0;
      row_count_q      <= '0;
      width_latch_q    <= '0;
      height_latch_q   <= '0;
      blit_active_q    <= 1'b0;
      valid_q          <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      // configuration word
      if (cfg_valid_i) begin
        unique case (reg_index_e'(cfg_index_i))
          REG_LAYER_MASK:    layer_mask_q    <= cfg_data_i[3:0];
          REG_SCROLL_X:      scroll_x_q      <= cfg_data_i;
          REG_SCROLL_Y:      scroll_y_q      <= cfg_data_i;
          REG_PLANE_CONTROL: plane_control_q <= cfg_data_i[5:0];
          REG_COLOR_MASKS:   color_masks_q   <= cfg_data_i[5:0];
          default:           ;
        endcase
      end
      // blit start latches, blit data advances
      if (accept && (act_in == ACT_BLIT_START)) begin
        source_counter_q <= blit_source_start_i;
        row_dest_base_q  <= blit_dest_start_i;
        width_latch_q    <= blit_width_i;
        height_latch_q   <= blit_height_i;
        column_count_q   <= '0;
        row_count_q      <= '0;
        blit_active_q    <= 1'b1;
      end else if (accept && (act_in == ACT_BLIT_DATA) && blit_active_q) begin
        source_counter_q <= source_counter_q + 16'd1;
        if (last_col) begin
          column_count_q  <= '0;
          row_dest_base_q <= row_dest_base_q + 16'd256;
          if (last_step) begin
            blit_active_q <= 1'b0;
          end else begin
            row_count_q <= row_count_q + 8'd1;
          end
        end else begin
          column_count_q <= column_count_q + 8'd1;
        end
      end
    end
  end

  // word in flight and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q    <= act_in;
      xa_lo_q  <= xa[1:0];
      xb_lo_q  <= xb[1:0];
      pen1_q   <= '0;
      pen2_q   <= '0;
      src_q    <= '0;
      done_q   <= 1'b0;
      err_q    <= 1'b0;
      unique case (act_in)
        ACT_CPU_WRITE: begin
          addr_q   <= write_address_i;
          byte_a_q <= write_byte_i;
          byte_b_q <= '0;
        end
        ACT_BLIT_DATA: begin
          addr_q   <= blit_dst;
          byte_a_q <= plane_a_byte_i;
          byte_b_q <= plane_b_byte_i;
          if (blit_active_q) begin
            src_q  <= src_sel[12:0];
            done_q <= last_step;
          end else begin
            err_q  <= 1'b1;
          end
        end
        ACT_PIXEL_FETCH: begin
          addr_q <= pix_addr_b;
        end
        default: begin
          addr_q <= blit_dst;
        end
      endcase
    end
    if (state_q == ST_FETCH_B) begin
      pa_q <= ram_rdata[{xa_lo_q, 3'b000} +: 4];
    end
    if (state_q == ST_MIX) begin
      pen1_q <= mix_pen1;
      pen2_q <= mix_pen2;
    end
  end

  // mixer controls from plane control and colour masks
  always_comb begin
    mix_ctrl.ena    = plane_control_q[3];
    mix_ctrl.enb    = plane_control_q[2];
    mix_ctrl.pra    = !plane_control_q[1];
    mix_ctrl.prb    = !plane_control_q[0];
    mix_ctrl.mask_a = {1'b0, color_masks_q[5], 1'b0, color_masks_q[3]};
    mix_ctrl.mask_b = {1'b0, color_masks_q[2:0]};
  end

  assign pb_nib = ram_rdata[{xb_lo_q, 3'b100} +: 4];

  pvrb_mix u_mix (
    .ctrl_i       (mix_ctrl),
    .pa_i         (pa_q),
    .pb_i         (pb_nib),
    .pen_first_o  (mix_pen1),
    .pen_second_o (mix_pen2)
  );

  pvrb_ram #(
    .WIDTH (WordW),
    .DEPTH (VramWords)
  ) u_vram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign valid_o       = valid_q;
  assign pen_first_o   = pen1_q;
  assign pen_second_o  = pen2_q;
  assign blit_source_o = src_q;
  assign blit_done_o   = done_q;
  assign blit_error_o  = err_q;

endmodule

// ===== tb/sv/tb_planar_video_ram_blitter_mixer.sv =====
// testbench of the planar video ram blitter mixer: directed and random words checked by a model
module tb_planar_video_ram_blitter_mixer;
  timeunit 1ns;
  timeprecision 1ps;

  import pvrb_pkg::*;

  // one command word as the driver puts it on the ports
  typedef struct {
    action_e     act;
    logic [13:0] waddr;
    logic [7:0]  wbyte;
    logic [15:0] src;
    logic [15:0] dst;
    logic [7:0]  bw;
    logic [7:0]  bh;
    logic [7:0]  pa;
    logic [7:0]  pb;
    logic [7:0]  col;
    logic [7:0]  row;
  } vram_cmd_t;

  // one result word
  typedef struct packed {
    logic [2:0]  pen1;
    logic [2:0]  pen2;
    logic [12:0] src;
    logic        done;
    logic        err;
  } outcome_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          action_i = '0;
  logic [13:0]         write_address_i = '0;
  logic [7:0]          write_byte_i = '0;
  logic [15:0]         blit_source_start_i = '0;
  logic [15:0]         blit_dest_start_i = '0;
  logic [7:0]          blit_width_i = '0;
  logic [7:0]          blit_height_i = '0;
  logic [7:0]          plane_a_byte_i = '0;
  logic [7:0]          plane_b_byte_i = '0;
  logic [7:0]          pixel_col_i = '0;
  logic [7:0]          pixel_row_i = '0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                valid_o;
  logic [2:0]          pen_first_o;
  logic [2:0]          pen_second_o;
  logic [12:0]         blit_source_o;
  logic                blit_done_o;
  logic                blit_error_o;

  planar_video_ram_blitter_mixer dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .action_i           (action_i),
    .write_address_i    (write_address_i),
    .write_byte_i       (write_byte_i),
    .blit_source_start_i(blit_source_start_i),
    .blit_dest_start_i  (blit_dest_start_i),
    .blit_width_i       (blit_width_i),
    .blit_height_i      (blit_height_i),
    .plane_a_byte_i     (plane_a_byte_i),
    .plane_b_byte_i     (plane_b_byte_i),
    .pixel_col_i        (pixel_col_i),
    .pixel_row_i        (pixel_row_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .valid_o            (valid_o),
    .pen_first_o        (pen_first_o),
    .pen_second_o       (pen_second_o),
    .blit_source_o      (blit_source_o),
    .blit_done_o        (blit_done_o),
    .blit_error_o       (blit_error_o)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // model of the video ram, the blitter and the registers
  logic [31:0] vram_model [VramWords];
  logic [15:0] src_ctr;
  logic [15:0] row_base;
  logic [7:0]  col_ctr;
  logic [7:0]  row_ctr;
  logic [7:0]  span_w;
  logic [7:0]  span_h;
  logic        blit_busy;
  logic [3:0]  lmask_cfg;
  logic [7:0]  scroll_x_cfg;
  logic [7:0]  scroll_y_cfg;
  logic [5:0]  plane_ctl;
  logic [5:0]  color_mask_cfg;

  // stimulus side
  vram_cmd_t   cmd_q [$];
  outcome_t    pending_outcomes [$];
  logic [13:0] hot_addr [$];
  int          queued = 0;
  int          idle_left = 0;
  int          err_count = 0;
  bit          steady_feed = 1'b0;
  logic [3:0]  gen_lmask;
  logic [7:0]  gen_scroll_x;
  logic [7:0]  gen_scroll_y;
  logic [5:0]  gen_ctl;
  logic [5:0]  gen_cmask;

  // merge a DCBADCBA byte into one ram word under the layer mask
  function automatic void merge_pixels(logic [13:0] addr, logic [7:0] b, logic [3:0] lm);
    logic [31:0] pix;
    logic [31:0] lanes;
    for (int k = 0; k < 4; k++) begin
      pix[8*k +: 8]   = (b[k] ? 8'h55 : 8'h00) | (b[k+4] ? 8'haa : 8'h00);
      lanes[8*k +: 8] = {{2{lm[2]}}, {2{lm[3]}}, {2{lm[0]}}, {2{lm[1]}}};
    end
    vram_model[addr] = (vram_model[addr] & ~lanes) | (pix & lanes);
  endfunction

  // apply one word to the model and return the result it must give
  function automatic outcome_t vram_step(vram_cmd_t c);
    outcome_t    o;
    logic [3:0]  m;
    logic [13:0] dst;
    logic [7:0]  xa;
    logic [7:0]  ya;
    logic [7:0]  xb;
    logic [7:0]  yb;
    logic [31:0] wa;
    logic [31:0] wb;
    logic [3:0]  pa;
    logic [3:0]  pb;
    logic [3:0]  f;
    logic        sel_a;
    logic        sel_b;
    o = '0;
    case (c.act)
      ACT_CPU_WRITE: begin
        merge_pixels(c.waddr, c.wbyte, lmask_cfg);
      end
      ACT_BLIT_START: begin
        src_ctr   = c.src;
        row_base  = c.dst;
        span_w    = c.bw;
        span_h    = c.bh;
        col_ctr   = '0;
        row_ctr   = '0;
        blit_busy = 1'b1;
      end
      ACT_BLIT_DATA: begin
        if (!blit_busy) begin
          o.err = 1'b1;
        end else begin
          // a mask half that is partly set opens both of its bits
          m = lmask_cfg;
          if (m[3:2] != 2'b00) m[3:2] = 2'b11;
          if (m[1:0] != 2'b00) m[1:0] = 2'b11;
          dst = row_base[13:0] + col_ctr;
          merge_pixels(dst, c.pa, m & 4'b0101);
          merge_pixels(dst, c.pb, m & 4'b1010);
          o.src   = 13'(src_ctr & 16'(GfxHalfBytesDefault - 1));
          src_ctr = src_ctr + 16'd1;
          if (col_ctr == span_w) begin
            col_ctr  = '0;
            row_base = row_base + 16'd256;
            if (row_ctr == span_h) begin
              blit_busy = 1'b0;
              o.done    = 1'b1;
            end else begin
              row_ctr = row_ctr + 8'd1;
            end
          end else begin
            col_ctr = col_ctr + 8'd1;
          end
        end
      end
      default: begin
        // layer a is flipped then scrolled, layer b only flipped
        xa = scroll_x_cfg + (c.col ^ {8{plane_ctl[5]}});
        ya = scroll_y_cfg + (c.row ^ {8{plane_ctl[5]}});
        xb = c.col ^ {8{plane_ctl[4]}};
        yb = c.row ^ {8{plane_ctl[4]}};
        wa = vram_model[{xa[7:2], ya}];
        wb = vram_model[{xb[7:2], yb}];
        pa = wa[8*xa[1:0] +: 4];
        pb = wb[8*xb[1:0] + 4 +: 4];
        sel_a = plane_ctl[3] && (!plane_ctl[1] || pb == 4'd0);
        sel_b = plane_ctl[2] && (!plane_ctl[0] || pa == 4'd0);
        f = (sel_a ? pa : 4'd0) | (sel_b ? pb : 4'd0);
        o.pen1 = f[2:0];
        // second pixel: masks only hit pens below 8, b sees the masked a
        if (sel_a && !pa[3]) pa = pa & {1'b0, color_mask_cfg[5], 1'b0, color_mask_cfg[3]};
        if (!pb[3]) pb = pb & {1'b0, color_mask_cfg[2:0]};
        sel_b = plane_ctl[2] && (!plane_ctl[0] || pa == 4'd0);
        f = (sel_a ? pa : 4'd0) | (sel_b ? pb : 4'd0);
        o.pen2 = f[2:0];
      end
    endcase
    return o;
  endfunction

  // gap before the next word: none half the time or always under steady feed, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_feed || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // driver: presents the oldest pending word until it is taken
  always @(posedge clk_i) begin : drive
    if (rst_ni && (!start || !busy)) begin
      if (start) begin
        cmd_q.delete(0);
        idle_left = pick_gap();
      end
      if (idle_left != 0) begin
        idle_left = idle_left - 1;
        start <= 1'b0;
      end else if (cmd_q.size() != 0) begin
        start               <= 1'b1;
        action_i            <= cmd_q[0].act;
        write_address_i     <= cmd_q[0].waddr;
        write_byte_i        <= cmd_q[0].wbyte;
        blit_source_start_i <= cmd_q[0].src;
        blit_dest_start_i   <= cmd_q[0].dst;
        blit_width_i        <= cmd_q[0].bw;
        blit_height_i       <= cmd_q[0].bh;
        plane_a_byte_i      <= cmd_q[0].pa;
        plane_b_byte_i      <= cmd_q[0].pb;
        pixel_col_i         <= cmd_q[0].col;
        pixel_row_i         <= cmd_q[0].row;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_count++;
    end
  endtask

  // monitor: checks results, tracks register writes and predicts taken words
  always @(posedge clk_i) begin : watch
    outcome_t  got;
    outcome_t  want;
    vram_cmd_t c;
    if (!rst_ni) begin
      foreach (vram_model[i]) vram_model[i] = '0;
      src_ctr        = '0;
      row_base       = '0;
      col_ctr        = '0;
      row_ctr        = '0;
      span_w         = '0;
      span_h         = '0;
      blit_busy      = 1'b0;
      lmask_cfg      = '0;
      scroll_x_cfg   = '0;
      scroll_y_cfg   = '0;
      plane_ctl      = '0;
      color_mask_cfg = '0;
    end else begin
      if (valid_o) begin
        got = {pen_first_o, pen_second_o, blit_source_o, blit_done_o, blit_error_o};
        if (pending_outcomes.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          err_count++;
        end else begin
          want = pending_outcomes.pop_front();
          check_field("pen_first", want.pen1, got.pen1);
          check_field("pen_second", want.pen2, got.pen2);
          check_field("blit_source", want.src, got.src);
          check_field("blit_done", want.done, got.done);
          check_field("blit_error", want.err, got.err);
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_LAYER_MASK:    lmask_cfg      = cfg_data_i[3:0];
          REG_SCROLL_X:      scroll_x_cfg   = cfg_data_i;
          REG_SCROLL_Y:      scroll_y_cfg   = cfg_data_i;
          REG_PLANE_CONTROL: plane_ctl      = cfg_data_i[5:0];
          REG_COLOR_MASKS:   color_mask_cfg = cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        c.act   = action_e'(action_i);
        c.waddr = write_address_i;
        c.wbyte = write_byte_i;
        c.src   = blit_source_start_i;
        c.dst   = blit_dest_start_i;
        c.bw    = blit_width_i;
        c.bh    = blit_height_i;
        c.pa    = plane_a_byte_i;
        c.pb    = plane_b_byte_i;
        c.col   = pixel_col_i;
        c.row   = pixel_row_i;
        pending_outcomes.push_back(vram_step(c));
      end
    end
  end

  // word of the given action with every other field random
  function automatic vram_cmd_t rand_cmd(action_e a);
    vram_cmd_t c;
    c.act   = a;
    c.waddr = 14'($urandom);
    c.wbyte = 8'($urandom);
    c.src   = 16'($urandom);
    c.dst   = 16'($urandom);
    c.bw    = 8'($urandom);
    c.bh    = 8'($urandom);
    c.pa    = 8'($urandom);
    c.pb    = 8'($urandom);
    c.col   = 8'($urandom);
    c.row   = 8'($urandom);
    return c;
  endfunction

  function automatic void note_addr(logic [13:0] a);
    hot_addr.push_back(a);
    if (hot_addr.size() > 48) hot_addr.delete(0);
  endfunction

  function automatic void push_cmd(vram_cmd_t c);
    cmd_q.push_back(c);
    queued++;
    if (c.act == ACT_CPU_WRITE) note_addr(c.waddr);
  endfunction

  function automatic vram_cmd_t write_cmd(logic [13:0] a, logic [7:0] b);
    vram_cmd_t c;
    c       = rand_cmd(ACT_CPU_WRITE);
    c.waddr = a;
    c.wbyte = b;
    return c;
  endfunction

  function automatic vram_cmd_t blit_cmd(logic [15:0] s, logic [15:0] d, logic [7:0] w,
                                         logic [7:0] h);
    vram_cmd_t c;
    c     = rand_cmd(ACT_BLIT_START);
    c.src = s;
    c.dst = d;
    c.bw  = w;
    c.bh  = h;
    return c;
  endfunction

  function automatic vram_cmd_t data_cmd(logic [7:0] a, logic [7:0] b);
    vram_cmd_t c;
    c    = rand_cmd(ACT_BLIT_DATA);
    c.pa = a;
    c.pb = b;
    return c;
  endfunction

  function automatic vram_cmd_t fetch_cmd(logic [7:0] x, logic [7:0] y);
    vram_cmd_t c;
    c     = rand_cmd(ACT_PIXEL_FETCH);
    c.col = x;
    c.row = y;
    return c;
  endfunction

  // cpu write, half of them onto words already written
  function automatic vram_cmd_t pick_write();
    vram_cmd_t c;
    c = rand_cmd(ACT_CPU_WRITE);
    if (hot_addr.size() != 0 && $urandom_range(0, 1) == 1)
      c.waddr = hot_addr[$urandom_range(0, hot_addr.size() - 1)];
    return c;
  endfunction

  // pixel fetch, mostly aimed at a written word through layer a or layer b
  function automatic vram_cmd_t pick_fetch();
    vram_cmd_t   c;
    logic [13:0] a;
    logic [7:0]  x;
    logic [7:0]  y;
    c = rand_cmd(ACT_PIXEL_FETCH);
    if (hot_addr.size() != 0 && $urandom_range(0, 3) != 0) begin
      a = hot_addr[$urandom_range(0, hot_addr.size() - 1)];
      x = {a[13:8], 2'($urandom)};
      y = a[7:0];
      if ($urandom_range(0, 1) == 1) begin
        c.col = (x - gen_scroll_x) ^ {8{gen_ctl[5]}};
        c.row = (y - gen_scroll_y) ^ {8{gen_ctl[5]}};
      end else begin
        c.col = x ^ {8{gen_ctl[4]}};
        c.row = y ^ {8{gen_ctl[4]}};
      end
    end
    return c;
  endfunction

  // complete blit with a cpu write or fetch slipped in now and then
  task automatic queue_blit_run(int w, int h);
    logic [15:0] d;
    d = 16'($urandom);
    push_cmd(blit_cmd(16'($urandom), d, 8'(w), 8'(h)));
    for (int r = 0; r <= h; r++) begin
      for (int k = 0; k <= w; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          if ($urandom_range(0, 1) == 1) push_cmd(pick_write());
          else push_cmd(pick_fetch());
        end
        push_cmd(rand_cmd(ACT_BLIT_DATA));
        note_addr(14'(d + 256 * r + k));
      end
    end
  endtask

  task automatic run_random_phase(int n, bit wide_blit);
    int stop_at;
    int r;
    stop_at = queued + n;
    if (wide_blit) queue_blit_run($urandom_range(200, 255), 0);
    while (queued < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        queue_blit_run($urandom_range(0, 3), $urandom_range(0, 3));
      end else if (r < 55) begin
        push_cmd(pick_write());
      end else if (r < 85) begin
        push_cmd(pick_fetch());
      end else if (r < 90) begin
        push_cmd(rand_cmd(ACT_BLIT_DATA));
      end else if (r < 95) begin
        // blit of random span cut short by whatever comes next
        push_cmd(rand_cmd(ACT_BLIT_START));
        repeat ($urandom_range(0, 3)) push_cmd(rand_cmd(ACT_BLIT_DATA));
      end else begin
        push_cmd(rand_cmd(action_e'($urandom_range(0, 3))));
      end
    end
  endtask

  task automatic write_reg(reg_index_e idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_phase_config();
    write_reg(REG_LAYER_MASK, {4'd0, gen_lmask});
    write_reg(REG_SCROLL_X, gen_scroll_x);
    write_reg(REG_SCROLL_Y, gen_scroll_y);
    write_reg(REG_PLANE_CONTROL, {2'd0, gen_ctl});
    write_reg(REG_COLOR_MASKS, {2'd0, gen_cmask});
  endtask

  // wait until every queued word is taken and every result is back
  task automatic wait_idle();
    while (cmd_q.size() != 0 || start || pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // stimulus
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed words: both layers open, no scroll, priority on
    gen_lmask    = 4'hf;
    gen_scroll_x = 8'h00;
    gen_scroll_y = 8'h00;
    gen_ctl      = 6'h0c;
    gen_cmask    = 6'h2a;
    apply_phase_config();
    push_cmd(data_cmd(8'hff, 8'hff));
    push_cmd(write_cmd(14'h0000, 8'hff));
    push_cmd(write_cmd(14'h3fff, 8'h0f));
    push_cmd(write_cmd(14'h1234, 8'h5a));
    push_cmd(fetch_cmd(8'h00, 8'h00));
    push_cmd(fetch_cmd(8'hff, 8'hff));
    push_cmd(fetch_cmd(8'h49, 8'h34));
    // source and destination at the top of their range wrap
    push_cmd(blit_cmd(16'hffff, 16'hffff, 8'd1, 8'd1));
    push_cmd(data_cmd(8'hff, 8'h00));
    push_cmd(write_cmd(14'h0001, 8'ha5));
    push_cmd(data_cmd(8'h00, 8'hff));
    push_cmd(fetch_cmd(8'h00, 8'hff));
    push_cmd(data_cmd(8'ha5, 8'h5a));
    push_cmd(data_cmd(8'hff, 8'hff));
    push_cmd(data_cmd(8'h12, 8'h34));
    push_cmd(blit_cmd(16'h0000, 16'h0000, 8'd0, 8'd0));
    push_cmd(data_cmd(8'h80, 8'h01));
    // restart while a blit is running
    push_cmd(blit_cmd(16'h1ffe, 16'h3ffe, 8'd3, 8'd2));
    push_cmd(data_cmd(8'h7e, 8'he7));
    push_cmd(blit_cmd(16'h0100, 16'h00ff, 8'd0, 8'd0));
    push_cmd(data_cmd(8'h01, 8'h80));
    push_cmd(fetch_cmd(8'h00, 8'hfe));
    push_cmd(fetch_cmd(8'h3f, 8'hff));
    wait_idle();

    // random phases, each with its own register setting
    for (int ph = 0; ph < 8; ph++) begin
      gen_lmask    = 4'($urandom);
      gen_scroll_x = 8'($urandom);
      gen_scroll_y = 8'($urandom);
      gen_ctl      = 6'($urandom);
      gen_cmask    = 6'($urandom);
      if ($urandom_range(0, 3) != 0) gen_ctl[3:2] = 2'b11;
      case (ph)
        0: begin
          gen_lmask    = 4'hf;
          gen_scroll_x = 8'hff;
          gen_scroll_y = 8'hff;
          gen_ctl      = 6'h3f;
          gen_cmask    = 6'h3f;
        end
        1: begin
          gen_lmask    = 4'h0;
          gen_scroll_x = 8'h00;
          gen_scroll_y = 8'h00;
          gen_ctl      = 6'h00;
          gen_cmask    = 6'h00;
        end
        // no scroll and equal flips so both layers land on one word
        2: begin
          gen_scroll_x = 8'h00;
          gen_scroll_y = 8'h00;
          gen_ctl[5:2] = 4'b0011;
        end
        3: begin
          gen_scroll_x = 8'h00;
          gen_scroll_y = 8'h00;
          gen_ctl[5:2] = 4'b1111;
        end
        default: ;
      endcase
      steady_feed = (ph == 2);
      apply_phase_config();
      run_random_phase(90, ph == 3);
      wait_idle();
    end

    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== files.f =====
src/pvrb_pkg.sv
src/pvrb_ram.sv
src/pvrb_mix.sv
src/planar_video_ram_blitter_mixer.sv
tb/sv/tb_planar_video_ram_blitter_mixer.sv
